// ----- rtl/core/pdfohs_pkg.sv -----
// ----------------------------------------------------------------------------
// pdfohs_pkg
// Shared types and constants for the PDF object header scanner.
// ----------------------------------------------------------------------------
package pdfohs_pkg;

	// Default width of the region byte counter
	localparam int POSITION_BITS_DEF = 32;

	// APB address width: one 32-bit register at byte address 0
	localparam int PADDR_W = 3;
	localparam logic REG_BASE_OFFSET = 1'b0;

	// Field widths
	localparam int NUM_W = 24;
	localparam int REV_W = 16;

	// Saturation limits
	localparam logic [NUM_W-1:0] NUM_MAX = 24'hFF_FFFF;
	localparam logic [REV_W-1:0] REV_MAX = 16'hFFFF;

	// Keyword patterns, most recent byte in the low bits
	localparam logic [31:0] HDR_PATTERN = 32'h206F_626A;      // " obj"
	localparam logic [47:0] END_PATTERN = 48'h656E_646F_626A; // "endobj"

	// Character codes
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SP = 8'd32;

	// Scan phase
	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_SKIP,
		PH_BODY,
		PH_STOPPED
	} phase_t;

	// Current values of the first two tokens of the line
	typedef struct packed {
		logic [NUM_W-1:0] first;
		logic [REV_W-1:0] second;
	} tok_t;

endpackage

// ----- rtl/core/pdfohs_byte_if.sv -----
// ----------------------------------------------------------------------------
// pdfohs_byte_if
// Valid/ready channel carrying one raw byte of the scanned region.
// ----------------------------------------------------------------------------
interface pdfohs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ----- rtl/core/pdfohs_obj_if.sv -----
// ----------------------------------------------------------------------------
// pdfohs_obj_if
// Valid/ready channel carrying one found indirect object.
// ----------------------------------------------------------------------------
interface pdfohs_obj_if;
	logic        valid;
	logic        ready;
	logic [23:0] object_number;
	logic [15:0] revision_number;
	logic [31:0] data_start;
	logic [31:0] data_length;

	modport source (output valid, object_number, revision_number, data_start, data_length,
		input ready);
	modport sink   (input valid, object_number, revision_number, data_start, data_length,
		output ready);
endinterface

// ----- rtl/core/pdf_object_header_scanner_core.sv -----
// ----------------------------------------------------------------------------
// pdf_object_header_scanner_core
// Finds "N G obj ... endobj" objects in a byte stream and reports their
// number, revision, data start and data length.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while no result waits; the scan state is updated
//   in the cycle a byte is accepted and the result register takes a new object at once.
// A result is valid in the cycle after the byte that completes "endobj".
// The input stalls only while a result waits in the output register.
// Reset (arst_n low) clears scan state, byte counter and base_offset;
//   the last byte of a region returns the scan state and counter to reset.
// ----------------------------------------------------------------------------
module pdf_object_header_scanner_core #(
	parameter int POSITION_BITS = pdfohs_pkg::POSITION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pdfohs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	pdfohs_byte_if.sink                    bytes,
	pdfohs_obj_if.source                   objects
);
	import pdfohs_pkg::*;

	localparam int EXT_W = (POSITION_BITS > 32) ? POSITION_BITS : 32;

	// Configuration
	logic [31:0] base_q;

	// Scan state
	phase_t                   phase_q;
	phase_t                   phase_d;
	logic [POSITION_BITS-1:0] pos_q;
	logic [47:0]              recent_q;
	logic [NUM_W-1:0]         held_num_q;
	logic [REV_W-1:0]         held_rev_q;
	logic [POSITION_BITS-1:0] held_start_q;
	tok_t                     tok;

	// Result register
	logic              out_valid_q;
	logic [NUM_W-1:0]  out_num_q;
	logic [REV_W-1:0]  out_rev_q;
	logic [31:0]       out_start_q;
	logic [31:0]       out_len_q;

	logic                     accept;
	logic [47:0]              recent_d;
	logic                     hdr_hit;
	logic                     end_hit;
	logic                     is_ws;
	logic [POSITION_BITS-1:0] span;
	logic [POSITION_BITS-1:0] len;
	logic                     empty_body;
	logic                     emit;
	logic                     load_header;
	logic                     load_start;
	logic [EXT_W-1:0]         start_ext;
	logic [EXT_W-1:0]         len_ext;

	// APB register port
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_BASE_OFFSET) ? base_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
		end else if (psel && penable && pwrite && pready
			&& paddr[PADDR_W-1] == REG_BASE_OFFSET) begin
			base_q <= pwdata;
		end
	end

	// Take a byte whenever the result register is free or being drained
	assign bytes.ready = !out_valid_q || objects.ready;
	assign accept      = bytes.valid && bytes.ready;

	// Byte matching against the keyword window
	assign recent_d   = {recent_q[39:0], bytes.data_byte};
	assign hdr_hit    = recent_d[31:0] == HDR_PATTERN;
	assign end_hit    = recent_d == END_PATTERN;
	assign is_ws      = bytes.data_byte == CH_LF || bytes.data_byte == CH_CR
		|| bytes.data_byte == CH_SP;
	assign span       = pos_q - held_start_q;
	assign len        = span - POSITION_BITS'(6);
	assign empty_body = span <= POSITION_BITS'(5);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_SEARCH:  if (hdr_hit) phase_d = PH_SKIP;
			PH_SKIP:    if (!is_ws) phase_d = PH_BODY;
			PH_BODY:    if (end_hit) phase_d = empty_body ? PH_STOPPED : PH_SEARCH;
			PH_STOPPED: phase_d = PH_STOPPED;
			default:    phase_d = PH_SEARCH;
		endcase
	end

	// Phase outputs
	always_comb begin
		emit        = 1'b0;
		load_header = 1'b0;
		load_start  = 1'b0;
		case (phase_q)
			PH_SEARCH:  load_header = hdr_hit;
			PH_SKIP:    load_start  = !is_ws;
			PH_BODY:    emit        = end_hit && !empty_body;
			PH_STOPPED: emit        = 1'b0;
			default:    emit        = 1'b0;
		endcase
	end

	// Advance scan state per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SEARCH;
			pos_q        <= '0;
			recent_q     <= '0;
			held_num_q   <= '0;
			held_rev_q   <= '0;
			held_start_q <= '0;
		end else if (accept) begin
			if (bytes.last_byte) begin
				phase_q      <= PH_SEARCH;
				pos_q        <= '0;
				recent_q     <= '0;
				held_num_q   <= '0;
				held_rev_q   <= '0;
				held_start_q <= '0;
			end else begin
				phase_q  <= phase_d;
				pos_q    <= pos_q + POSITION_BITS'(1);
				recent_q <= recent_d;
				if (load_header) begin
					held_num_q <= tok.first;
					held_rev_q <= tok.second;
				end
				if (load_start) begin
					held_start_q <= pos_q;
				end
			end
		end
	end

	pdfohs_tokens u_tokens (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.clear     (bytes.last_byte),
		.data_byte (bytes.data_byte),
		.tok       (tok)
	);

	// Fit positions to the 32-bit result fields
	assign start_ext = EXT_W'(held_start_q);
	assign len_ext   = EXT_W'(len);

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (objects.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_num_q   <= held_num_q;
			out_rev_q   <= held_rev_q;
			out_start_q <= base_q + start_ext[31:0];
			out_len_q   <= len_ext[31:0];
		end
	end

	assign objects.valid           = out_valid_q;
	assign objects.object_number   = out_num_q;
	assign objects.revision_number = out_rev_q;
	assign objects.data_start      = out_start_q;
	assign objects.data_length     = out_len_q;

	// Checks
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && bytes.last_byte |=> pos_q == '0 && phase_q == PH_SEARCH)
		else $error("scan state not cleared after last byte");

	a_pos_steps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !bytes.last_byte |=> pos_q == $past(pos_q) + POSITION_BITS'(1))
		else $error("byte position did not advance");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> bytes.ready)
		else $error("input stalled with empty result register");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STOPPED && !(accept && bytes.last_byte) |=> phase_q == PH_STOPPED)
		else $error("stopped scan resumed before region end");

	a_no_emit_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |-> !out_valid_q || objects.ready)
		else $error("result overwritten before transfer");

endmodule

// ----- rtl/core/pdfohs_tokens.sv -----
// ----------------------------------------------------------------------------
// pdfohs_tokens
// Tracks the first two space-separated decimal tokens of the current line.
// ----------------------------------------------------------------------------
module pdfohs_tokens (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              clear,
	input  logic [7:0]        data_byte,
	output pdfohs_pkg::tok_t  tok
);
	import pdfohs_pkg::*;

	logic [1:0]       idx_q;
	logic [1:0]       frozen_q;
	logic [NUM_W-1:0] first_q;
	logic [REV_W-1:0] second_q;

	logic [1:0]       idx_d;
	logic [1:0]       frozen_d;
	logic [NUM_W-1:0] first_d;
	logic [REV_W-1:0] second_d;

	logic             is_digit;
	logic [3:0]       digit;
	logic [NUM_W+3:0] first_acc;
	logic [REV_W+3:0] second_acc;

	// Decimal accumulate, v*10 + digit
	assign digit      = data_byte[3:0];
	assign is_digit   = data_byte inside {[8'd48:8'd57]};
	assign first_acc  = {1'b0, first_q, 3'b000} + {3'b000, first_q, 1'b0}
		+ {(NUM_W)'(0), digit};
	assign second_acc = {1'b0, second_q, 3'b000} + {3'b000, second_q, 1'b0}
		+ {(REV_W)'(0), digit};

	// Next token state for the current byte
	always_comb begin
		idx_d    = idx_q;
		frozen_d = frozen_q;
		first_d  = first_q;
		second_d = second_q;
		if (data_byte == CH_LF || data_byte == CH_CR) begin
			idx_d    = 2'd0;
			frozen_d = 2'b00;
			first_d  = '0;
			second_d = '0;
		end else if (data_byte == CH_SP) begin
			if (idx_q != 2'd2) begin
				idx_d = idx_q + 2'd1;
			end
		end else if (idx_q == 2'd0) begin
			if (!frozen_q[0]) begin
				if (is_digit) begin
					first_d = (first_acc[NUM_W+3:NUM_W] != 4'd0) ? NUM_MAX
						: first_acc[NUM_W-1:0];
				end else begin
					frozen_d[0] = 1'b1;
				end
			end
		end else if (idx_q == 2'd1) begin
			if (!frozen_q[1]) begin
				if (is_digit) begin
					second_d = (second_acc[REV_W+3:REV_W] != 4'd0) ? REV_MAX
						: second_acc[REV_W-1:0];
				end else begin
					frozen_d[1] = 1'b1;
				end
			end
		end
	end

	// Update on each accepted byte; return to line start at region end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 2'd0;
			frozen_q <= 2'b00;
			first_q  <= '0;
			second_q <= '0;
		end else if (advance) begin
			if (clear) begin
				idx_q    <= 2'd0;
				frozen_q <= 2'b00;
				first_q  <= '0;
				second_q <= '0;
			end else begin
				idx_q    <= idx_d;
				frozen_q <= frozen_d;
				first_q  <= first_d;
				second_q <= second_d;
			end
		end
	end

	assign tok.first  = first_q;
	assign tok.second = second_q;

endmodule

// ----- bench/pdf_object_header_scanner_core_tb.sv -----
// ----------------------------------------------------------------------------
// pdf_object_header_scanner_core_tb
// Streams byte regions into the scanner and checks every reported object
// against a cycle-free scan of the same bytes kept in an object ledger.
// A short directed region covers saturated tokens, all blank kinds, extreme
// byte values, an empty body and the last-byte flush. Random regions then mix
// well-formed objects with noise and broken headers under three idle mixes
// and several base offsets.
// ----------------------------------------------------------------------------
module pdf_object_header_scanner_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pdfohs_pkg::*;

	localparam logic [PADDR_W-1:0] BASE_OFFSET_ADDR = PADDR_W'(4 * REG_BASE_OFFSET);
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;

	typedef logic [POSITION_BITS_DEF-1:0] pos_t;

	typedef struct {
		logic [NUM_W-1:0] object_number;
		logic [REV_W-1:0] revision_number;
		logic [31:0]      data_start;
		logic [31:0]      data_length;
	} found_obj_t;

	// Scan state mirror plus the queue of objects still owed by the block
	class object_ledger;
		logic [31:0]      base_offset;
		phase_t           phase;
		pos_t             position;
		logic [47:0]      recent;
		logic [1:0]       token_idx;
		logic [NUM_W-1:0] first_tok;
		logic [REV_W-1:0] second_tok;
		logic [1:0]       frozen;
		logic [NUM_W-1:0] held_number;
		logic [REV_W-1:0] held_revision;
		pos_t             held_start;
		found_obj_t       pending[$];
		int unsigned      failures;
		int unsigned      objects_predicted;

		function new();
			base_offset = '0;
			failures = 0;
			objects_predicted = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			phase = PH_SEARCH;
			position = '0;
			recent = '0;
			token_idx = '0;
			first_tok = '0;
			second_tok = '0;
			frozen = '0;
			held_number = '0;
			held_revision = '0;
			held_start = '0;
		endfunction

		function longint unsigned add_digit(longint unsigned acc, logic [7:0] ch,
			longint unsigned cap);
			longint unsigned n;
			n = acc * 10 + (ch - CH_ZERO);
			return (n > cap) ? cap : n;
		endfunction

		// Line break clears, space advances, first non-digit freezes the token
		function void track_tokens(logic [7:0] ch);
			logic [1:0] sel_mask;
			sel_mask = 2'b01 << token_idx;
			if (ch == CH_LF || ch == CH_CR) begin
				token_idx = '0;
				first_tok = '0;
				second_tok = '0;
				frozen = '0;
			end else if (ch == CH_SP) begin
				if (token_idx < 2) token_idx++;
			end else if (token_idx < 2 && (frozen & sel_mask) == 0) begin
				if (ch >= CH_ZERO && ch <= CH_NINE) begin
					if (token_idx == 0)
						first_tok = NUM_W'(add_digit(first_tok, ch, NUM_MAX));
					else
						second_tok = REV_W'(add_digit(second_tok, ch, REV_MAX));
				end else begin
					frozen |= sel_mask;
				end
			end
		endfunction

		// Advance the scan by one accepted transfer
		function void note_byte(logic [7:0] ch, logic last);
			pos_t       span;
			found_obj_t obj;
			recent = {recent[39:0], ch};
			case (phase)
				PH_SEARCH: begin
					if (recent[31:0] == HDR_PATTERN) begin
						held_number = first_tok;
						held_revision = second_tok;
						phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (ch != CH_LF && ch != CH_CR && ch != CH_SP) begin
						held_start = position;
						phase = PH_BODY;
					end
				end
				PH_BODY: begin
					if (recent == END_PATTERN) begin
						span = position - held_start;
						if (span <= 5) begin
							// endobj right at the data start: stop until region end
							phase = PH_STOPPED;
						end else begin
							obj.object_number = held_number;
							obj.revision_number = held_revision;
							obj.data_start = 32'(base_offset + 32'(held_start));
							obj.data_length = 32'(pos_t'(span - 6));
							pending.insert(pending.size(), obj);
							objects_predicted++;
							phase = PH_SEARCH;
						end
					end
				end
				default: ;
			endcase
			track_tokens(ch);
			position = position + 1'b1;
			if (last) clear_scan();
		endfunction

		function void match_object(logic [NUM_W-1:0] num, logic [REV_W-1:0] rev,
			logic [31:0] start, logic [31:0] len);
			found_obj_t want;
			if (pending.size() == 0) begin
				$error("unexpected object: number %0d revision %0d start %0d length %0d",
					num, rev, start, len);
				failures++;
				return;
			end
			want = pending.pop_front();
			if (num !== want.object_number) begin
				$error("object_number: expected %0d, got %0d", want.object_number, num);
				failures++;
			end
			if (rev !== want.revision_number) begin
				$error("revision_number: expected %0d, got %0d", want.revision_number, rev);
				failures++;
			end
			if (start !== want.data_start) begin
				$error("data_start: expected %0d, got %0d", want.data_start, start);
				failures++;
			end
			if (len !== want.data_length) begin
				$error("data_length: expected %0d, got %0d", want.data_length, len);
				failures++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	pdfohs_byte_if byte_ch ();
	pdfohs_obj_if  obj_ch ();

	object_ledger ledger = new();
	int           src_idle;
	int           dst_idle;
	int unsigned  bytes_sent;
	int unsigned  config_errors;

	pdf_object_header_scanner_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bytes   (byte_ch),
		.objects (obj_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		obj_ch.ready <= ($urandom_range(99) >= dst_idle);
	end

	// Check every object transfer
	always @(posedge clk) begin
		if (arst_n && obj_ch.valid && obj_ch.ready)
			ledger.match_object(obj_ch.object_number, obj_ch.revision_number,
				obj_ch.data_start, obj_ch.data_length);
	end

	task automatic push_byte(logic [7:0] value, logic last);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= value;
		byte_ch.last_byte <= last;
		do @(posedge clk); while (!byte_ch.ready);
		ledger.note_byte(value, last);
		bytes_sent++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	task automatic push_digits(int unsigned count);
		repeat (count) push_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
	endtask

	// Drop valid and hold until every owed object has come out
	task automatic hold_until_drained();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (ledger.pending.size() != 0) @(negedge clk);
	endtask

	// Drop valid and wait for the block to go quiet
	task automatic settle();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write base_offset, then read it back
	task automatic write_base(logic [31:0] value);
		logic [31:0] got;
		settle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BASE_OFFSET_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ledger.base_offset = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== value) begin
			$error("base_offset: expected %0h, got %0h", value, got);
			config_errors++;
		end
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(2))
			0: return CH_LF;
			1: return CH_CR;
			default: return CH_SP;
		endcase
	endfunction

	function automatic logic [7:0] body_byte();
		if ($urandom_range(3) == 0) return 8'($urandom_range(255));
		return 8'($urandom_range(33, 126));
	endfunction

	// One "N G obj ... endobj" object with random tokens, blanks and body
	task automatic emit_object(bit fresh);
		if (!fresh || $urandom_range(1) == 1) begin
			case ($urandom_range(2))
				0: push_byte(CH_LF, 1'b0);
				1: push_byte(CH_CR, 1'b0);
				default: begin
					push_byte(CH_CR, 1'b0);
					push_byte(CH_LF, 1'b0);
				end
			endcase
		end
		push_digits(($urandom_range(9) == 0) ? $urandom_range(8, 11) : $urandom_range(4));
		if ($urandom_range(9) == 0) push_byte(8'($urandom_range(97, 122)), 1'b0);
		push_byte(CH_SP, 1'b0);
		if ($urandom_range(9) == 0) push_byte(CH_SP, 1'b0);
		push_digits(($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(2));
		push_text(" obj");
		repeat ($urandom_range(3)) push_byte(pick_blank(), 1'b0);
		if ($urandom_range(9) != 0)
			repeat ($urandom_range(1, 16)) push_byte(body_byte(), 1'b0);
		push_text("endobj");
	endtask

	// Noise, stray keywords and headers that never close
	task automatic emit_noise();
		case ($urandom_range(3))
			0: repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)), 1'b0);
			1: push_text("endobj");
			2: begin
				push_byte(CH_LF, 1'b0);
				push_digits($urandom_range(1, 3));
				push_text(" 0 obj ");
				repeat ($urandom_range(4)) push_byte(body_byte(), 1'b0);
			end
			default: begin
				push_text(" ob");
				push_byte(8'($urandom_range(255)), 1'b0);
			end
		endcase
	endtask

	task automatic scan_random_regions(int unsigned target_bytes, int unsigned target_objects);
		int unsigned first_byte;
		int unsigned first_object;
		bit          fresh;
		first_byte = bytes_sent;
		first_object = ledger.objects_predicted;
		fresh = 1'b1;
		while ((bytes_sent - first_byte < target_bytes ||
			ledger.objects_predicted - first_object < target_objects) &&
			bytes_sent - first_byte < 8 * target_bytes) begin
			if ($urandom_range(29) == 0) hold_until_drained();
			if ($urandom_range(9) < 7)
				emit_object(fresh);
			else
				emit_noise();
			fresh = 1'b0;
			// Close the region now and then, dropping anything open
			if ($urandom_range(11) == 0) begin
				push_byte(8'($urandom_range(255)), 1'b1);
				fresh = 1'b1;
			end
		end
		push_byte(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		obj_ch.ready = 1'b0;
		src_idle = 0;
		dst_idle = 0;
		bytes_sent = 0;
		config_errors = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_base(32'h0000_0000);

		// Saturated tokens on the first line, every blank, extreme byte values
		push_text("99999999 99999 obj");
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b0);
		push_byte(CH_SP, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_text("endobj");
		hold_until_drained();
		// Empty body stops the scan; the last byte then flushes it
		push_byte(CH_LF, 1'b0);
		push_text("3 7 obj endobj");
		push_byte("q", 1'b1);

		src_idle = 30;
		dst_idle = 52;
		write_base(32'hFFFF_FFFF);
		scan_random_regions(370, 14);

		src_idle = 52;
		dst_idle = 30;
		write_base($urandom);
		scan_random_regions(370, 14);

		src_idle = 0;
		dst_idle = 0;
		write_base(32'hFFFF_FFF0);
		scan_random_regions(370, 14);

		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (config_errors == 0 && ledger.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- pdf_object_header_scanner_core.f -----
rtl/core/pdfohs_pkg.sv
rtl/core/pdfohs_byte_if.sv
rtl/core/pdfohs_obj_if.sv
rtl/core/pdfohs_tokens.sv
rtl/core/pdf_object_header_scanner_core.sv
bench/pdf_object_header_scanner_core_tb.sv
